FILE: rtl/ic8_pkg.sv
package ic8_pkg;

    // Default widths of the coefficient input and of the fraction part.
    localparam int COEF_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF = 12;

    // Integer bits kept above the input range for butterfly growth.
    localparam int GUARD_BITS = 7;

    // Rotation constants, Q14: round(2^14 * sqrt(2) * cos/sin) and cos(pi/4).
    localparam logic signed [15:0] K_C7  = 16'sd4520;
    localparam logic signed [15:0] K_S7  = 16'sd22725;
    localparam logic signed [15:0] K_C3  = 16'sd19266;
    localparam logic signed [15:0] K_S3  = 16'sd12873;
    localparam logic signed [15:0] K_C38 = 16'sd8867;
    localparam logic signed [15:0] K_S38 = 16'sd21407;
    localparam logic signed [15:0] K_R2  = 16'sd11585;

    // Saturation bounds of an output sample.
    localparam int SAMPLE_MAX     = 255;
    localparam int SAMPLE_MIN_MAG = 256;

    // Number of items in one block.
    localparam int BLOCK_ITEMS = 64;

    // Status of the block queue as seen by the loader and the engine.
    typedef struct packed {
        logic not_empty;
        logic full;
        logic head_bank;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CALC,
        BK_WRITE,
        BK_EMIT
    } t_back_state;

endpackage

FILE: rtl/idct_8x8_chen_saturating.sv
// 8x8 inverse DCT (Chen butterfly) with saturated 9-bit samples. Coefficients of
// a block enter in row order, one item per cycle while the queue has room, into
// one of two coefficient banks; the 64th item hands the block to the transform
// engine through a two-entry queue, so the next block can load while the previous
// one is being transformed. The engine runs a four-stage pipelined 1-D butterfly
// over the eight rows and then the eight columns; each line is read from the
// one-read-per-cycle coefficient or transpose memory, passed through the
// butterfly and stored in the transpose memory, or for columns the sample memory.
// It then sends the 64 samples in row order from the registered sample memory,
// waiting for each read before it issues the next, the last one flagged with
// o_last_sample. Each sample is twice the 2-D result, rounded half away from
// zero and clamped to -256..255. The output register holds a finished sample
// while the input side keeps loading.
module idct_8x8_chen_saturating #(
    parameter int COEF_BITS = ic8_pkg::COEF_BITS_DEF,
    parameter int FRAC_BITS = ic8_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COEF_BITS-1:0] i_coefficient,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [8:0]    o_sample,
    output logic                 o_last_sample
);

    ic8_pkg::t_q_status   w_q;
    logic                 w_wr_en;
    logic [6:0]           w_wr_addr;
    logic [COEF_BITS-1:0] w_wr_data;
    logic                 w_push;
    logic                 w_push_bank;
    logic                 w_pop;
    logic [6:0]           w_rd_addr;
    logic [COEF_BITS-1:0] w_rd_data;

    // Loader: writes each item into the current bank and queues full banks.
    ic8_front #(.COEF_BITS(COEF_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_coefficient (i_coefficient),
        .i_q           (w_q),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_push        (w_push),
        .o_push_bank   (w_push_bank)
    );

    // Queue of complete blocks waiting for the engine.
    ic8_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_bank (w_push_bank),
        .i_pop       (w_pop),
        .o_status    (w_q)
    );

    // Two coefficient banks, selected by the top address bit.
    ic8_ram #(.WIDTH(COEF_BITS), .DEPTH(2 * ic8_pkg::BLOCK_ITEMS)) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Transform engine and output stage.
    ic8_back #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (w_q),
        .o_pop         (w_pop),
        .o_coef_addr   (w_rd_addr),
        .i_coef_data   (w_rd_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample      (o_sample),
        .o_last_sample (o_last_sample)
    );

`ifndef SYNTHESIS
    // A block is only queued when the queue has room for it.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q.full)
        else $error("block queued while queue full");

    // The engine only releases a bank that was queued.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q.not_empty)
        else $error("block released from empty queue");

    // A full queue always stalls the input.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q.full |-> !o_ready)
        else $error("input ready while both banks are pending");
`endif

endmodule

FILE: rtl/ic8_ram.sv
module ic8_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ic8_queue.sv
module ic8_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_push_bank,
    input  logic                i_pop,
    output ic8_pkg::t_q_status  o_status
);

    logic       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_slot[r_wp] <= i_push_bank;
        end
    end

    assign o_status.not_empty = (r_cnt != 2'd0);
    assign o_status.full      = (r_cnt == 2'd2);
    assign o_status.head_bank = r_slot[r_rp];

endmodule

FILE: rtl/ic8_front.sv
module ic8_front #(
    parameter int COEF_BITS = ic8_pkg::COEF_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COEF_BITS-1:0] i_coefficient,
    input  ic8_pkg::t_q_status   i_q,
    output logic                 o_wr_en,
    output logic [6:0]           o_wr_addr,
    output logic [COEF_BITS-1:0] o_wr_data,
    output logic                 o_push,
    output logic                 o_push_bank
);

    logic [5:0] r_cnt;
    logic       r_bank;
    logic [5:0] n_cnt;
    logic       n_bank;
    logic       accept;
    logic       last;

    // The loader may fill a bank only while the queue has room for its token.
    assign o_ready = !i_q.full;
    assign accept  = i_valid && o_ready;
    assign last    = (r_cnt == 6'(ic8_pkg::BLOCK_ITEMS - 1));

    always_comb begin
        n_cnt  = r_cnt;
        n_bank = r_bank;
        if (accept) begin
            n_cnt = r_cnt + 6'd1;
            if (last) begin
                n_bank = ~r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 6'd0;
            r_bank <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_bank <= n_bank;
        end
    end

    assign o_wr_en     = accept;
    assign o_wr_addr   = {r_bank, r_cnt};
    assign o_wr_data   = i_coefficient;
    assign o_push      = accept && last;
    assign o_push_bank = r_bank;

endmodule

FILE: rtl/ic8_butterfly.sv
module ic8_butterfly #(
    parameter int W = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x [8],
    output logic                o_valid,
    output logic signed [W-1:0] o_y [8]
);

    logic signed [W-1:0] r_s1 [8];
    logic signed [W-1:0] r_s2 [8];
    logic signed [W-1:0] r_s3 [8];
    logic signed [W-1:0] r_s4 [8];
    logic [3:0]          r_v;

    // Weighted sum a*ka + b*kb, rounded once at 14 fraction bits.
    function automatic logic signed [W-1:0] ws(
        input logic signed [W-1:0] a,
        input logic signed [15:0]  ka,
        input logic signed [W-1:0] b,
        input logic signed [15:0]  kb
    );
        logic signed [W+17:0] p;
        p = a * ka + b * kb;
        p = p + 8192;
        return W'(p >>> 14);
    endfunction

    // Half of a sum or difference, rounded toward minus infinity after adding one.
    function automatic logic signed [W-1:0] hs(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b,
        input logic                sub
    );
        logic signed [W:0] s;
        s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
        s = s + 1;
        return W'(s >>> 1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'd0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end

        // Stage 1: rotations of the odd inputs; the even inputs pass through reordered.
        r_s1[0] <= i_x[0];
        r_s1[1] <= i_x[4];
        r_s1[2] <= i_x[2];
        r_s1[3] <= i_x[6];
        r_s1[4] <= ws(i_x[1], ic8_pkg::K_C7, i_x[7], -ic8_pkg::K_S7);
        r_s1[7] <= ws(i_x[1], ic8_pkg::K_S7, i_x[7], ic8_pkg::K_C7);
        r_s1[5] <= ws(i_x[5], ic8_pkg::K_C3, i_x[3], -ic8_pkg::K_S3);
        r_s1[6] <= ws(i_x[5], ic8_pkg::K_S3, i_x[3], ic8_pkg::K_C3);

        // Stage 2.
        r_s2[0] <= r_s1[0] + r_s1[1];
        r_s2[1] <= r_s1[0] - r_s1[1];
        r_s2[2] <= ws(r_s1[2], ic8_pkg::K_C38, r_s1[3], -ic8_pkg::K_S38);
        r_s2[3] <= ws(r_s1[2], ic8_pkg::K_S38, r_s1[3], ic8_pkg::K_C38);
        r_s2[4] <= hs(r_s1[4], r_s1[5], 1'b0);
        r_s2[5] <= hs(r_s1[4], r_s1[5], 1'b1);
        r_s2[6] <= hs(r_s1[7], r_s1[6], 1'b1);
        r_s2[7] <= hs(r_s1[6], r_s1[7], 1'b0);

        // Stage 3.
        r_s3[0] <= hs(r_s2[0], r_s2[3], 1'b0);
        r_s3[3] <= hs(r_s2[0], r_s2[3], 1'b1);
        r_s3[1] <= hs(r_s2[1], r_s2[2], 1'b0);
        r_s3[2] <= hs(r_s2[1], r_s2[2], 1'b1);
        r_s3[4] <= r_s2[4];
        r_s3[5] <= ws(r_s2[6], ic8_pkg::K_R2, r_s2[5], -ic8_pkg::K_R2);
        r_s3[6] <= ws(r_s2[5], ic8_pkg::K_R2, r_s2[6], ic8_pkg::K_R2);
        r_s3[7] <= r_s2[7];

        // Stage 4: output butterflies.
        r_s4[0] <= hs(r_s3[0], r_s3[7], 1'b0);
        r_s4[7] <= hs(r_s3[0], r_s3[7], 1'b1);
        r_s4[1] <= hs(r_s3[1], r_s3[6], 1'b0);
        r_s4[6] <= hs(r_s3[1], r_s3[6], 1'b1);
        r_s4[2] <= hs(r_s3[2], r_s3[5], 1'b0);
        r_s4[5] <= hs(r_s3[2], r_s3[5], 1'b1);
        r_s4[3] <= hs(r_s3[3], r_s3[4], 1'b0);
        r_s4[4] <= hs(r_s3[3], r_s3[4], 1'b1);
    end

    assign o_valid = r_v[3];
    assign o_y     = r_s4;

endmodule

FILE: rtl/ic8_back.sv
module ic8_back #(
    parameter int COEF_BITS = ic8_pkg::COEF_BITS_DEF,
    parameter int FRAC_BITS = ic8_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ic8_pkg::t_q_status   i_q,
    output logic                 o_pop,
    output logic [6:0]           o_coef_addr,
    input  logic [COEF_BITS-1:0] i_coef_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [8:0]    o_sample,
    output logic                 o_last_sample
);

    localparam int W = COEF_BITS + FRAC_BITS + ic8_pkg::GUARD_BITS;
    localparam logic [W+1:0] HALF = (W+2)'(1) << (FRAC_BITS - 1);

    ic8_pkg::t_back_state r_state, n_state;
    logic                 r_pass, n_pass;
    logic [2:0]           r_line, n_line;
    logic [3:0]           r_cnt, n_cnt;
    logic                 r_start, n_start;
    logic [6:0]           r_ecnt, n_ecnt;
    logic                 r_rd_pend, n_rd_pend;
    logic                 r_pend_last, n_pend_last;
    logic                 r_out_valid, n_out_valid;
    logic signed [8:0]    r_sample, n_sample;
    logic                 r_last, n_last;
    logic signed [W-1:0]  r_x [8];
    logic signed [W-1:0]  r_y [8];

    logic signed [W-1:0]  bf_y [8];
    logic                 bf_valid;
    logic [W-1:0]         tr_rd;
    logic [8:0]           sm_rd;
    logic signed [W-1:0]  coef_ext;
    logic [2:0]           cap_idx;
    logic                 issue;

    // Twice the value, rounded half away from zero, saturated.
    function automatic logic signed [8:0] to_sample(input logic signed [W-1:0] v);
        logic signed [W:0] d;
        logic [W:0]        ad;
        logic [W+1:0]      rs;
        logic              neg;
        d   = (W+1)'(v) <<< 1;
        neg = d[W];
        ad  = neg ? (W+1)'(-d) : (W+1)'(d);
        rs  = ((W+2)'(ad) + HALF) >> FRAC_BITS;
        if (!neg) begin
            return (rs > (W+2)'(ic8_pkg::SAMPLE_MAX)) ? 9'(ic8_pkg::SAMPLE_MAX) : 9'(rs);
        end
        return (rs > (W+2)'(ic8_pkg::SAMPLE_MIN_MAG))
            ? 9'((W+2)'(0) - (W+2)'(ic8_pkg::SAMPLE_MIN_MAG)) : 9'((W+2)'(0) - rs);
    endfunction

    always_comb begin
        coef_ext = W'(signed'(i_coef_data));
        coef_ext = coef_ext <<< FRAC_BITS;
    end

    assign cap_idx = 3'(r_cnt - 4'd1);
    assign issue   = (r_state == ic8_pkg::BK_EMIT) && !r_rd_pend
                     && (r_ecnt != 7'(ic8_pkg::BLOCK_ITEMS)) && (!r_out_valid || i_ready);

    ic8_butterfly #(.W(W)) u_bf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_start),
        .i_x     (r_x),
        .o_valid (bf_valid),
        .o_y     (bf_y)
    );

    // Row results, stored row by row and read back down each column.
    ic8_ram #(.WIDTH(W), .DEPTH(ic8_pkg::BLOCK_ITEMS)) u_tr_ram (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == ic8_pkg::BK_WRITE) && !r_pass),
        .i_wr_addr ({r_line, r_cnt[2:0]}),
        .i_wr_data (r_y[r_cnt[2:0]]),
        .i_rd_addr ({r_cnt[2:0], r_line}),
        .o_rd_data (tr_rd)
    );

    // Final samples, written by column and read out in row order.
    ic8_ram #(.WIDTH(9), .DEPTH(ic8_pkg::BLOCK_ITEMS)) u_sm_ram (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == ic8_pkg::BK_WRITE) && r_pass),
        .i_wr_addr ({r_cnt[2:0], r_line}),
        .i_wr_data (to_sample(r_y[r_cnt[2:0]])),
        .i_rd_addr (r_ecnt[5:0]),
        .o_rd_data (sm_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_line      = r_line;
        n_cnt       = r_cnt;
        n_start     = 1'b0;
        n_ecnt      = r_ecnt;
        n_rd_pend   = 1'b0;
        n_pend_last = r_pend_last;
        o_pop       = 1'b0;
        unique case (r_state)
            ic8_pkg::BK_IDLE: begin
                if (i_q.not_empty) begin
                    n_state = ic8_pkg::BK_READ;
                    n_pass  = 1'b0;
                    n_line  = 3'd0;
                    n_cnt   = 4'd0;
                end
            end
            ic8_pkg::BK_READ: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd8) begin
                    n_state = ic8_pkg::BK_CALC;
                    n_start = 1'b1;
                    n_cnt   = 4'd0;
                end
            end
            ic8_pkg::BK_CALC: begin
                if (bf_valid) begin
                    n_state = ic8_pkg::BK_WRITE;
                    n_cnt   = 4'd0;
                end
            end
            ic8_pkg::BK_WRITE: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd7) begin
                    n_cnt = 4'd0;
                    if (r_line == 3'd7) begin
                        n_line = 3'd0;
                        if (!r_pass) begin
                            n_pass  = 1'b1;
                            n_state = ic8_pkg::BK_READ;
                        end else begin
                            n_state = ic8_pkg::BK_EMIT;
                            n_ecnt  = 7'd0;
                            o_pop   = 1'b1;
                        end
                    end else begin
                        n_line  = r_line + 3'd1;
                        n_state = ic8_pkg::BK_READ;
                    end
                end
            end
            ic8_pkg::BK_EMIT: begin
                if (issue) begin
                    n_ecnt      = r_ecnt + 7'd1;
                    n_rd_pend   = 1'b1;
                    n_pend_last = (r_ecnt == 7'(ic8_pkg::BLOCK_ITEMS - 1));
                end
                if ((r_ecnt == 7'(ic8_pkg::BLOCK_ITEMS)) && !r_rd_pend) begin
                    n_state = ic8_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ic8_pkg::BK_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_last      = r_last;
        if (r_rd_pend) begin
            n_out_valid = 1'b1;
            n_sample    = signed'(sm_rd);
            n_last      = r_pend_last;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ic8_pkg::BK_IDLE;
            r_pass      <= 1'b0;
            r_line      <= 3'd0;
            r_cnt       <= 4'd0;
            r_start     <= 1'b0;
            r_ecnt      <= 7'd0;
            r_rd_pend   <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_line      <= n_line;
            r_cnt       <= n_cnt;
            r_start     <= n_start;
            r_ecnt      <= n_ecnt;
            r_rd_pend   <= n_rd_pend;
            r_pend_last <= n_pend_last;
            r_out_valid <= n_out_valid;
        end
        r_sample <= n_sample;
        r_last   <= n_last;
        if ((r_state == ic8_pkg::BK_READ) && (r_cnt != 4'd0)) begin
            r_x[cap_idx] <= r_pass ? signed'(tr_rd) : coef_ext;
        end
        if ((r_state == ic8_pkg::BK_CALC) && bf_valid) begin
            r_y <= bf_y;
        end
    end

    assign o_coef_addr   = {i_q.head_bank, r_line, r_cnt[2:0]};
    assign o_valid       = r_out_valid;
    assign o_sample      = r_sample;
    assign o_last_sample = r_last;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the 8x8 Chen inverse DCT.
// Coefficients are driven in row order, 64 to a block. The scoreboard keeps its
// own 64-bit fixed-point model of the two-pass butterfly transform. On the 64th
// coefficient of each block it queues the 64 saturated samples it expects. Every
// sample that leaves the block is compared with the oldest queued sample.
class idct_scoreboard;
    typedef longint t_vec8[8];

    longint   coef_block[64];
    int       load_index;
    bit [8:0] sample_q[$];
    bit       last_q[$];
    int       errors;

    function new();
        load_index = 0;
        errors     = 0;
    endfunction

    // Weighted sum with a single rounding of the Q14 product.
    function longint rotate(longint a, longint ka, longint b, longint kb);
        return (a * ka + b * kb + 64'sd8192) >>> 14;
    endfunction

    // Product of a sum by one half, rounded toward plus infinity on ties.
    function longint halve(longint a, longint b);
        return (a + b + 64'sd1) >>> 1;
    endfunction

    // One 1-D Chen butterfly: four stages.
    function t_vec8 butterfly(t_vec8 s);
        t_vec8  d;
        longint x4, x5, x6, x7, y0, y1, y2, y3, y4, y5, y6, y7;
        longint z0, z1, z2, z3, z5, z6;
        x4 = rotate(s[1], ic8_pkg::K_C7, s[7], -ic8_pkg::K_S7);
        x7 = rotate(s[1], ic8_pkg::K_S7, s[7], ic8_pkg::K_C7);
        x5 = rotate(s[5], ic8_pkg::K_C3, s[3], -ic8_pkg::K_S3);
        x6 = rotate(s[5], ic8_pkg::K_S3, s[3], ic8_pkg::K_C3);
        y0 = s[0] + s[4];
        y1 = s[0] - s[4];
        y2 = rotate(s[2], ic8_pkg::K_C38, s[6], -ic8_pkg::K_S38);
        y3 = rotate(s[2], ic8_pkg::K_S38, s[6], ic8_pkg::K_C38);
        y4 = halve(x4, x5);
        y5 = halve(x4, -x5);
        y6 = halve(x7, -x6);
        y7 = halve(x6, x7);
        z0 = halve(y0, y3);
        z3 = halve(y0, -y3);
        z1 = halve(y1, y2);
        z2 = halve(y1, -y2);
        z5 = rotate(y6, ic8_pkg::K_R2, y5, -ic8_pkg::K_R2);
        z6 = rotate(y5, ic8_pkg::K_R2, y6, ic8_pkg::K_R2);
        d[0] = halve(z0, y7);
        d[7] = halve(z0, -y7);
        d[1] = halve(z1, z6);
        d[6] = halve(z1, -z6);
        d[2] = halve(z2, z5);
        d[5] = halve(z2, -z5);
        d[3] = halve(z3, y4);
        d[4] = halve(z3, -y4);
        return d;
    endfunction

    // Double, round half away from zero, clamp to the 9-bit sample range.
    function bit [8:0] saturate(longint v);
        longint dbl, half, r;
        dbl  = 2 * v;
        half = 64'sd1 <<< (ic8_pkg::FRAC_BITS_DEF - 1);
        if (dbl >= 0) begin
            r = (dbl + half) >>> ic8_pkg::FRAC_BITS_DEF;
        end else begin
            r = -((-dbl + half) >>> ic8_pkg::FRAC_BITS_DEF);
        end
        if (r < -ic8_pkg::SAMPLE_MIN_MAG) r = -ic8_pkg::SAMPLE_MIN_MAG;
        if (r > ic8_pkg::SAMPLE_MAX) r = ic8_pkg::SAMPLE_MAX;
        return r[8:0];
    endfunction

    // Called for every accepted coefficient.
    function void note_coefficient(logic [11:0] coef);
        longint work[64];
        t_vec8  line, res;
        coef_block[load_index] = longint'($signed(coef));
        if (load_index != ic8_pkg::BLOCK_ITEMS - 1) begin
            load_index++;
            return;
        end
        load_index = 0;
        for (int r = 0; r < 8; r++) begin
            for (int k = 0; k < 8; k++) line[k] = coef_block[8*r+k] <<< ic8_pkg::FRAC_BITS_DEF;
            res = butterfly(line);
            for (int k = 0; k < 8; k++) work[8*r+k] = res[k];
        end
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < 8; k++) line[k] = work[c+8*k];
            res = butterfly(line);
            for (int k = 0; k < 8; k++) work[c+8*k] = res[k];
        end
        for (int i = 0; i < 64; i++) begin
            sample_q.push_back(saturate(work[i]));
            last_q.push_back(i == 63);
        end
    endfunction

    // Called for every accepted sample.
    function void check_sample(logic [8:0] sample, logic last);
        bit [8:0] exp_sample;
        bit       exp_last;
        if (sample_q.size() == 0) begin
            $display("%0t: unexpected sample %0d last %0b", $time, $signed(sample), last);
            errors++;
            return;
        end
        exp_sample = sample_q.pop_front();
        exp_last   = last_q.pop_front();
        if (sample !== exp_sample) begin
            $display("%0t: sample expected %0d actual %0d", $time,
                     $signed(exp_sample), $signed(sample));
            errors++;
        end
        if (last !== exp_last) begin
            $display("%0t: last_sample expected %0b actual %0b", $time, exp_last, last);
            errors++;
        end
    endfunction

    function int pending();
        return sample_q.size();
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to wait at the end, so that the engine drains fully.
    localparam int DRAIN_CYCLES = 1200;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [11:0]       i_coefficient;
    logic              o_valid;
    logic              i_ready;
    logic signed [8:0] o_sample;
    logic              o_last_sample;

    idct_scoreboard sb;
    int             cycles = 0;
    int             idle_pct;    // chance that the sender leaves a gap
    int             stall_pct;   // chance that the receiver holds off

    idct_8x8_chen_saturating u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_coefficient (i_coefficient),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample      (o_sample),
        .o_last_sample (o_last_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A global watchdog, so that a hung block cannot hold the run forever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("idct_8x8_chen_saturating: mismatch");
            $finish;
        end
    end

    // The receiver decides on its ready at every falling edge. Stalls are drawn
    // independently each cycle, so they land on every phase of the output.
    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Output samples are taken at the rising edge, when the handshake completes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_sample(o_sample, o_last_sample);
    end

    // Drive one coefficient; the random gap comes first so that valid, once
    // raised, stays high with a steady payload until the item is taken.
    task automatic send_coefficient(input logic [11:0] coef);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_coefficient <= coef;
        do @(posedge i_clk); while (!o_ready);
        sb.note_coefficient(coef);
        @(negedge i_clk);
    endtask

    // Lower valid after the last item of a burst.
    task automatic go_quiet();
        i_valid <= 1'b0;
    endtask

    // A block with one constant value everywhere.
    task automatic send_flat_block(input logic [11:0] value);
        for (int i = 0; i < 64; i++) send_coefficient(value);
    endtask

    // A random block. Four in ten look like real video data: a few low-frequency
    // terms and zeros elsewhere. Others are full-range noise, saturating sign
    // patterns that drive the clamp on both sides, or small values near zero.
    task automatic send_random_block();
        int          style;
        logic [11:0] coef;
        style = $urandom_range(9);
        for (int i = 0; i < 64; i++) begin
            case (style)
                0, 1, 2, 3: begin
                    if ((i % 8) + (i / 8) < 4 && $urandom_range(2) != 0) begin
                        coef = 12'($signed($urandom_range(400)) - 200);
                    end else begin
                        coef = '0;
                    end
                    if (i == 0) coef = 12'($urandom);
                end
                4, 5, 6: coef = 12'($urandom);
                7: coef = ($urandom_range(1) != 0) ? 12'h7FF : 12'h800;
                default: coef = 12'($signed($urandom_range(31)) - 16);
            endcase
            send_coefficient(coef);
        end
    endtask

    // Wait until every queued sample has been seen.
    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb            = new();
        idle_pct      = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_coefficient = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed blocks: the positive field extreme everywhere, and a
        // DC-only block at the negative end of the range.
        send_flat_block(12'h7FF);
        for (int i = 0; i < 64; i++) send_coefficient(i == 0 ? 12'h800 : 12'h000);
        go_quiet();

        // Random blocks in several idling phases: none, sender gaps, receiver
        // stalls, and both together.
        for (int blk = 0; blk < 4; blk++) begin
            case (blk)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            // Once, hold the sender until the block is fully drained.
            if (blk == 2) begin
                go_quiet();
                wait_drained();
            end
            send_random_block();
        end
        go_quiet();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("idct_8x8_chen_saturating: match");
        end else begin
            $display("idct_8x8_chen_saturating: mismatch");
        end
        $finish;
    end
endmodule

FILE: idct_8x8_chen_saturating.f
rtl/ic8_pkg.sv
rtl/ic8_ram.sv
rtl/ic8_queue.sv
rtl/ic8_front.sv
rtl/ic8_butterfly.sv
rtl/ic8_back.sv
rtl/idct_8x8_chen_saturating.sv
bench/testbench.sv
